[sv/lcd_segment_ram_scan_driver_assert.svh]
// Assertion macros used by the display driver's sequencer (lcdseg_back).
// In simulation they expand to concurrent assertions; with SYNTH defined
// they expand to nothing.
`ifndef LCD_SEGMENT_RAM_SCAN_DRIVER_ASSERT_SVH
`define LCD_SEGMENT_RAM_SCAN_DRIVER_ASSERT_SVH

`ifndef SYNTH

// Same-cycle implication, disabled during reset.
`define LCDSEG_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: implication check failed");

// Next-cycle implication, disabled during reset.
`define LCDSEG_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");

`else

`define LCDSEG_ASSERT_IMP(label, clk, rst, ante, cons)

`define LCDSEG_ASSERT_NXT(label, clk, rst, ante, cons)

`endif

`endif

[sv/lcdseg_pkg.sv]
`default_nettype none

package lcdseg_pkg;

   // Display RAM geometry.
   localparam int RAM_DEPTH = 128;
   localparam int RAM_AW    = $clog2(RAM_DEPTH);
   localparam int DATA_W    = 8;
   localparam logic [RAM_AW-1:0] HIGH_PLANE = RAM_AW'(8'h40);

   // Segment and common limits.
   localparam int MAX_SEGMENTS = 42;
   localparam int SEG_W        = MAX_SEGMENTS;
   localparam int SEG_IW       = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
   localparam int SEG_CW       = $clog2(MAX_SEGMENTS + 1);
   localparam int MAX_COMMONS  = 16;
   localparam int COM_IW       = 4;
   localparam int COM_CW       = 5;

   // Register fields as seen on the configuration port.
   localparam int CFG_COM_W  = 5;
   localparam int CFG_SEG_W  = 6;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 6;
   localparam logic [CSR_IDX_W-1:0] CSR_COMMON_COUNT  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SEGMENT_COUNT = 2'd1;
   localparam logic [CFG_COM_W-1:0] COMMON_COUNT_RST  = 5'd8;
   localparam logic [CFG_SEG_W-1:0] SEGMENT_COUNT_RST = 6'd42;

   // Transaction kinds on the request side.
   localparam int KIND_W = 2;
   localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
   localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_TICK  = 2'd2;

   // Command classes handed from the front end to the sequencer.
   typedef enum logic [1:0] {
      CLS_NONE,
      CLS_WRITE,
      CLS_READ,
      CLS_TICK
   } cls_type;

   typedef struct packed {
      cls_type               cls;
      logic [RAM_AW-1:0]     address;
      logic [DATA_W-1:0]     write_data;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } cmd_if_type;

   // Effective (clamped) configuration.
   typedef struct packed {
      logic [COM_CW-1:0] commons;
      logic [SEG_CW-1:0] segments;
   } cfg_type;

   function automatic logic [COM_CW-1:0] eff_commons(input logic [CFG_COM_W-1:0] cnt);
      logic [COM_CW-1:0] res;
      if (cnt == '0) begin
         res = COM_CW'(1);
      end else if (int'(cnt) > MAX_COMMONS) begin
         res = COM_CW'(MAX_COMMONS);
      end else begin
         res = COM_CW'(cnt);
      end
      return res;
   endfunction

   function automatic logic [SEG_CW-1:0] eff_segments(input logic [CFG_SEG_W-1:0] cnt);
      logic [SEG_CW-1:0] res;
      if (int'(cnt) > MAX_SEGMENTS) begin
         res = SEG_CW'(MAX_SEGMENTS);
      end else begin
         res = SEG_CW'(cnt);
      end
      return res;
   endfunction

endpackage

`default_nettype wire

[sv/lcdseg_ram.sv]
`default_nettype none

module lcdseg_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output      logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

[sv/lcdseg_front.sv]
`default_nettype none

// Request front end: classifies each transaction and holds it in a
// two-entry queue until the sequencer takes it.
module lcdseg_front (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          push,
   output      logic                          full,
   input  wire logic [lcdseg_pkg::KIND_W-1:0] req_kind,
   input  wire logic [lcdseg_pkg::RAM_AW-1:0] req_address,
   input  wire logic [lcdseg_pkg::DATA_W-1:0] req_write_data,
   output      lcdseg_pkg::cmd_if_type        cmd_out,
   input  wire logic                          cmd_pop
);

   lcdseg_pkg::cmd_type q_ff [2];
   lcdseg_pkg::cmd_type q_in;
   logic                wr_ptr_ff, wr_ptr_in;
   logic                rd_ptr_ff, rd_ptr_in;
   logic [1:0]          count_ff, count_in;
   logic                do_push, do_pop;

   always_comb begin
      case (req_kind)
         lcdseg_pkg::KIND_WRITE: q_in.cls = lcdseg_pkg::CLS_WRITE;
         lcdseg_pkg::KIND_READ:  q_in.cls = lcdseg_pkg::CLS_READ;
         lcdseg_pkg::KIND_TICK:  q_in.cls = lcdseg_pkg::CLS_TICK;
         default:                q_in.cls = lcdseg_pkg::CLS_NONE;
      endcase
      q_in.address    = req_address;
      q_in.write_data = req_write_data;
   end

   assign full    = (count_ff == 2'd2);
   assign do_push = push && !full;
   assign do_pop  = cmd_pop && (count_ff != 2'd0);

   assign cmd_out.valid = (count_ff != 2'd0);
   assign cmd_out.cmd   = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop  ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         q_ff[wr_ptr_ff] <= q_in;
      end
   end

endmodule

`default_nettype wire

[sv/lcdseg_back.sv]
`default_nettype none

// Sequencer: runs one command at a time against the display RAM and
// leaves its result in the response register.
module lcdseg_back (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire lcdseg_pkg::cmd_if_type        cmd_in,
   output      logic                          cmd_pop,
   input  wire lcdseg_pkg::cfg_type           cfg,
   output      logic                          empty,
   input  wire logic                          pop,
   output      logic [lcdseg_pkg::DATA_W-1:0] rsp_read_data,
   output      logic                          rsp_segments_valid,
   output      logic [lcdseg_pkg::COM_IW-1:0] rsp_common_index,
   output      logic [lcdseg_pkg::SEG_W-1:0]  rsp_segments
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_RDATA  = 2'd1;
   localparam logic [1:0] ST_SCAN   = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   logic [1:0]                       state_ff, state_in;
   logic [lcdseg_pkg::COM_IW-1:0]    current_common_ff, current_common_in;
   logic                             is_tick_ff, is_tick_in;
   logic [lcdseg_pkg::COM_IW-1:0]    com_ff, com_in;
   logic [lcdseg_pkg::DATA_W-1:0]    rd_res_ff, rd_res_in;
   logic [lcdseg_pkg::SEG_W-1:0]     seg_ff, seg_in;
   logic [lcdseg_pkg::SEG_CW-1:0]    idx_ff, idx_in;
   logic [lcdseg_pkg::SEG_CW-1:0]    nseg_ff, nseg_in;
   logic [lcdseg_pkg::COM_CW-1:0]    ncom_ff, ncom_in;
   logic                             phase_ff, phase_in;
   logic                             tag_valid_ff, tag_valid_in;
   logic                             tag_hi_ff, tag_hi_in;
   logic [lcdseg_pkg::SEG_IW-1:0]    tag_idx_ff, tag_idx_in;
   logic [lcdseg_pkg::DATA_W-1:0]    lo_ff, lo_in;
   logic [lcdseg_pkg::COM_CW-1:0]    rem_ff, rem_in;
   logic [lcdseg_pkg::RAM_DEPTH-1:0] valid_ff, valid_in;
   logic                             rvalid_ff;

   logic                             out_valid_ff, out_valid_in;
   logic [lcdseg_pkg::DATA_W-1:0]    out_rd_ff;
   logic                             out_sv_ff;
   logic [lcdseg_pkg::COM_IW-1:0]    out_com_ff;
   logic [lcdseg_pkg::SEG_W-1:0]     out_seg_ff;

   logic                             ram_we;
   logic [lcdseg_pkg::RAM_AW-1:0]    ram_addr;
   logic [lcdseg_pkg::DATA_W-1:0]    ram_wdata;
   logic [lcdseg_pkg::DATA_W-1:0]    ram_q;
   logic [lcdseg_pkg::DATA_W-1:0]    rd_eff;
   logic [2*lcdseg_pkg::DATA_W-1:0]  pair;
   logic [lcdseg_pkg::SEG_CW-1:0]    idx_next;
   logic                             commit;

   lcdseg_ram #(
      .WIDTH(lcdseg_pkg::DATA_W),
      .DEPTH(lcdseg_pkg::RAM_DEPTH)
   ) u_ram (
      .clock(clock),
      .we   (ram_we),
      .addr (ram_addr),
      .wdata(ram_wdata),
      .rdata(ram_q)
   );

   // Entries never written read as zero, which gives the cleared RAM.
   assign rd_eff   = rvalid_ff ? ram_q : '0;
   assign pair     = {rd_eff, lo_ff};
   assign idx_next = idx_ff + lcdseg_pkg::SEG_CW'(1);
   assign commit   = (state_ff == ST_FINISH) && !tag_valid_ff && (rem_ff < ncom_ff)
                     && (!out_valid_ff || pop);

   always_comb begin
      state_in          = state_ff;
      current_common_in = current_common_ff;
      is_tick_in        = is_tick_ff;
      com_in            = com_ff;
      rd_res_in         = rd_res_ff;
      seg_in            = seg_ff;
      idx_in            = idx_ff;
      nseg_in           = nseg_ff;
      ncom_in           = ncom_ff;
      phase_in          = phase_ff;
      tag_valid_in      = 1'b0;
      tag_hi_in         = tag_hi_ff;
      tag_idx_in        = tag_idx_ff;
      lo_in             = lo_ff;
      rem_in            = rem_ff;
      valid_in          = valid_ff;
      ram_we            = 1'b0;
      ram_addr          = '0;
      ram_wdata         = '0;
      cmd_pop           = 1'b0;

      // Read data returns in the cycle after its address; fold it in here.
      if (tag_valid_ff) begin
         if (!tag_hi_ff) begin
            lo_in = rd_eff;
         end else begin
            seg_in[tag_idx_ff] = pair[com_ff];
         end
      end

      // Next common line: (common + 1) mod count by repeated subtraction.
      if (rem_ff >= ncom_ff) begin
         rem_in = rem_ff - ncom_ff;
      end

      case (state_ff)
         ST_IDLE: begin
            if (cmd_in.valid) begin
               cmd_pop    = 1'b1;
               is_tick_in = 1'b0;
               com_in     = '0;
               rd_res_in  = '0;
               seg_in     = '0;
               idx_in     = '0;
               phase_in   = 1'b0;
               rem_in     = '0;
               nseg_in    = cfg.segments;
               ncom_in    = cfg.commons;
               state_in   = ST_FINISH;
               case (cmd_in.cmd.cls)
                  lcdseg_pkg::CLS_WRITE: begin
                     ram_we   = 1'b1;
                     ram_addr = cmd_in.cmd.address;
                     ram_wdata = cmd_in.cmd.write_data;
                     valid_in[cmd_in.cmd.address] = 1'b1;
                  end
                  lcdseg_pkg::CLS_READ: begin
                     ram_addr = cmd_in.cmd.address;
                     state_in = ST_RDATA;
                  end
                  lcdseg_pkg::CLS_TICK: begin
                     is_tick_in = 1'b1;
                     com_in     = current_common_ff;
                     rem_in     = lcdseg_pkg::COM_CW'(current_common_ff)
                                  + lcdseg_pkg::COM_CW'(1);
                     if (cfg.segments != '0) begin
                        state_in = ST_SCAN;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_RDATA: begin
            rd_res_in = rd_eff;
            state_in  = ST_FINISH;
         end
         ST_SCAN: begin
            // Low byte on phase 0, high byte on phase 1.
            ram_addr     = phase_ff ? (lcdseg_pkg::RAM_AW'(idx_ff) | lcdseg_pkg::HIGH_PLANE)
                                    : lcdseg_pkg::RAM_AW'(idx_ff);
            tag_valid_in = 1'b1;
            tag_hi_in    = phase_ff;
            tag_idx_in   = lcdseg_pkg::SEG_IW'(idx_ff);
            phase_in     = !phase_ff;
            if (phase_ff) begin
               idx_in = idx_next;
               if (idx_next == nseg_ff) begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_FINISH: begin
            if (commit) begin
               state_in = ST_IDLE;
               if (is_tick_ff) begin
                  current_common_in = rem_ff[lcdseg_pkg::COM_IW-1:0];
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (commit) begin
         out_valid_in = 1'b1;
      end else if (pop) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_IDLE;
         current_common_ff <= '0;
         tag_valid_ff      <= 1'b0;
         valid_ff          <= '0;
         rvalid_ff         <= 1'b0;
         out_valid_ff      <= 1'b0;
      end else begin
         state_ff          <= state_in;
         current_common_ff <= current_common_in;
         tag_valid_ff      <= tag_valid_in;
         valid_ff          <= valid_in;
         rvalid_ff         <= valid_ff[ram_addr];
         out_valid_ff      <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      is_tick_ff <= is_tick_in;
      com_ff     <= com_in;
      rd_res_ff  <= rd_res_in;
      seg_ff     <= seg_in;
      idx_ff     <= idx_in;
      nseg_ff    <= nseg_in;
      ncom_ff    <= ncom_in;
      phase_ff   <= phase_in;
      tag_hi_ff  <= tag_hi_in;
      tag_idx_ff <= tag_idx_in;
      lo_ff      <= lo_in;
      rem_ff     <= rem_in;
      if (commit) begin
         out_rd_ff  <= rd_res_ff;
         out_sv_ff  <= is_tick_ff;
         out_com_ff <= com_ff;
         out_seg_ff <= seg_ff;
      end
   end

   assign empty              = !out_valid_ff;
   assign rsp_read_data      = out_rd_ff;
   assign rsp_segments_valid = out_sv_ff;
   assign rsp_common_index   = out_com_ff;
   assign rsp_segments       = out_seg_ff;

`include "lcd_segment_ram_scan_driver_assert.svh"

   `LCDSEG_ASSERT_IMP(a_nontick_zero, clock, reset, out_valid_ff && !out_sv_ff, (out_seg_ff == '0) && (out_com_ff == '0))
   `LCDSEG_ASSERT_IMP(a_tag_state, clock, reset, tag_valid_ff, (state_ff == ST_SCAN) || (state_ff == ST_FINISH))
   `LCDSEG_ASSERT_NXT(a_commit_fills, clock, reset, commit, out_valid_ff)
   `LCDSEG_ASSERT_IMP(a_scan_bound, clock, reset, state_ff == ST_SCAN, idx_ff < nseg_ff)

endmodule

`default_nettype wire

[sv/lcd_segment_ram_scan_driver.sv]
// Sequencing: a write passes through the finish state; a read through the
// read-data and finish states; a frame tick through the scan state, which
// reads two RAM bytes per segment on one port (skipped with no segments),
// then the finish state; the common wrap steps alongside, one subtraction
// a cycle. One transaction runs at a time; two more wait in the front queue.
// Reset: synchronous, active high; RAM reads as zero and registers reload.
`default_nettype none

// Top level of the multiplexed LCD segment driver.
//
// Requests enter through a queue-style port (push/full). A front end
// classifies each transaction as a RAM write, a RAM read or a frame tick
// and queues it. A sequencer takes one command at a time, works it against
// the 128-byte display RAM and puts exactly one response in an output
// register, read through empty/pop. Because the output register sits
// between the sequencer and the response side, new requests are still
// accepted while a finished response waits to be taken.
//
// A frame tick walks the segments one by one: for segment i it fetches the
// low byte at address i and the high byte at address i + 64, and segment i
// takes bit c of that 16-bit pair, c being the current common line. After
// the response is issued, the common counter advances modulo the common
// count.
//
// The two configuration registers (common count and segment count) are
// written through a valid/ready channel that is always ready. They must
// only be written while the block is idle.
module lcd_segment_ram_scan_driver (
   input  wire logic                              clock,
   input  wire logic                              reset,

   input  wire logic                              push,
   output      logic                              full,
   input  wire logic [lcdseg_pkg::KIND_W-1:0]     req_kind,
   input  wire logic [lcdseg_pkg::RAM_AW-1:0]     req_address,
   input  wire logic [lcdseg_pkg::DATA_W-1:0]     req_write_data,

   output      logic                              empty,
   input  wire logic                              pop,
   output      logic [lcdseg_pkg::DATA_W-1:0]     rsp_read_data,
   output      logic                              rsp_segments_valid,
   output      logic [lcdseg_pkg::COM_IW-1:0]     rsp_common_index,
   output      logic [lcdseg_pkg::SEG_W-1:0]      rsp_segments,

   input  wire logic                              csr_valid,
   output      logic                              csr_ready,
   input  wire logic [lcdseg_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [lcdseg_pkg::CSR_DATA_W-1:0] csr_data
);

   logic [lcdseg_pkg::CFG_COM_W-1:0] common_count_ff, common_count_in;
   logic [lcdseg_pkg::CFG_SEG_W-1:0] segment_count_ff, segment_count_in;
   lcdseg_pkg::cfg_type              cfg;
   lcdseg_pkg::cmd_if_type           cmd;
   logic                             cmd_pop;

   // The register file never stalls a write.
   assign csr_ready = 1'b1;

   always_comb begin
      common_count_in  = common_count_ff;
      segment_count_in = segment_count_ff;
      if (csr_valid) begin
         case (csr_index)
            lcdseg_pkg::CSR_COMMON_COUNT: begin
               common_count_in = csr_data[lcdseg_pkg::CFG_COM_W-1:0];
            end
            lcdseg_pkg::CSR_SEGMENT_COUNT: begin
               segment_count_in = csr_data[lcdseg_pkg::CFG_SEG_W-1:0];
            end
            default: begin
               // Writes to unused register indexes are dropped.
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         common_count_ff  <= lcdseg_pkg::COMMON_COUNT_RST;
         segment_count_ff <= lcdseg_pkg::SEGMENT_COUNT_RST;
      end else begin
         common_count_ff  <= common_count_in;
         segment_count_ff <= segment_count_in;
      end
   end

   // A common count of zero behaves as one; both counts clamp at their
   // maximum values.
   assign cfg.commons  = lcdseg_pkg::eff_commons(common_count_ff);
   assign cfg.segments = lcdseg_pkg::eff_segments(segment_count_ff);

   lcdseg_front u_front (
      .clock         (clock),
      .reset         (reset),
      .push          (push),
      .full          (full),
      .req_kind      (req_kind),
      .req_address   (req_address),
      .req_write_data(req_write_data),
      .cmd_out       (cmd),
      .cmd_pop       (cmd_pop)
   );

   lcdseg_back u_back (
      .clock             (clock),
      .reset             (reset),
      .cmd_in            (cmd),
      .cmd_pop           (cmd_pop),
      .cfg               (cfg),
      .empty             (empty),
      .pop               (pop),
      .rsp_read_data     (rsp_read_data),
      .rsp_segments_valid(rsp_segments_valid),
      .rsp_common_index  (rsp_common_index),
      .rsp_segments      (rsp_segments)
   );

endmodule

`default_nettype wire

[tb/tb_top.sv]
`default_nettype none

// Self-checking bench for the multiplexed LCD segment driver.
//
// Requests are queued by the main initial block and fed to the block by a
// clocked driver. The bench keeps its own shadow of the display RAM, the
// common counter and the two count registers. When a request transaction is
// accepted, the driver works out the one response that the request must
// produce and appends it to a queue. A clocked monitor takes responses
// through empty/pop and compares each one, field by field, with the oldest
// queued expectation.
//
// Both sides idle at random after each transaction, and now and then switch to
// a mode with no idling at all. Every 300 responses the monitor holds off
// popping, so that the block fills up and raises full while the driver keeps
// offering requests.
//
// Count registers are written only while the block is idle: no request is
// pending or offered, and every expected response has arrived. The bench then
// lets the block sit quiet before the write.
module tb_top;

   // Request kind with no function; it must leave the state alone.
   localparam logic [lcdseg_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;

   localparam int RANDOM_PHASES   = 12;
   localparam int PHASE_REQUESTS  = 68;
   localparam int DRAIN_CYCLES    = 40;
   localparam int HOLD_CYCLES     = 300;
   localparam int MAX_IDLE_CYCLES = 13;

   typedef struct packed {
      logic [lcdseg_pkg::KIND_W-1:0] kind;
      logic [lcdseg_pkg::RAM_AW-1:0] address;
      logic [lcdseg_pkg::DATA_W-1:0] write_data;
   } lcd_request_type;

   typedef struct packed {
      logic [lcdseg_pkg::DATA_W-1:0] read_data;
      logic                          segments_valid;
      logic [lcdseg_pkg::COM_IW-1:0] common_index;
      logic [lcdseg_pkg::SEG_W-1:0]  segments;
   } lcd_response_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                              push           = 1'b0;
   logic                              full;
   logic [lcdseg_pkg::KIND_W-1:0]     req_kind       = lcdseg_pkg::KIND_WRITE;
   logic [lcdseg_pkg::RAM_AW-1:0]     req_address    = '0;
   logic [lcdseg_pkg::DATA_W-1:0]     req_write_data = '0;

   logic                              empty;
   logic                              pop            = 1'b0;
   logic [lcdseg_pkg::DATA_W-1:0]     rsp_read_data;
   logic                              rsp_segments_valid;
   logic [lcdseg_pkg::COM_IW-1:0]     rsp_common_index;
   logic [lcdseg_pkg::SEG_W-1:0]      rsp_segments;

   logic                              csr_valid      = 1'b0;
   logic                              csr_ready;
   logic [lcdseg_pkg::CSR_IDX_W-1:0]  csr_index      = lcdseg_pkg::CSR_COMMON_COUNT;
   logic [lcdseg_pkg::CSR_DATA_W-1:0] csr_data       = '0;

   lcd_request_type  pending_requests [$];
   lcd_response_type expected_responses [$];
   lcd_request_type  offered_request = '0;

   int error_count     = 0;
   int responses_taken = 0;

   // Shadow state of the display: RAM, common counter and count registers.
   logic [lcdseg_pkg::DATA_W-1:0]    shadow_ram [lcdseg_pkg::RAM_DEPTH];
   logic [lcdseg_pkg::COM_IW-1:0]    scan_common  = '0;
   logic [lcdseg_pkg::CFG_COM_W-1:0] cfg_commons  = lcdseg_pkg::COMMON_COUNT_RST;
   logic [lcdseg_pkg::CFG_SEG_W-1:0] cfg_segments = lcdseg_pkg::SEGMENT_COUNT_RST;

   // Idle control of both sides.
   int   sender_gap     = 0;
   bit   sender_calm    = 1'b0;
   int   receiver_gap   = 0;
   int   receiver_hold  = 0;
   bit   receiver_calm  = 1'b0;

   lcd_segment_ram_scan_driver i_dut (
      .clock              (clock),
      .reset              (reset),
      .push               (push),
      .full               (full),
      .req_kind           (req_kind),
      .req_address        (req_address),
      .req_write_data     (req_write_data),
      .empty              (empty),
      .pop                (pop),
      .rsp_read_data      (rsp_read_data),
      .rsp_segments_valid (rsp_segments_valid),
      .rsp_common_index   (rsp_common_index),
      .rsp_segments       (rsp_segments),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   always #10 clock = ~clock;

   // Applies one request to the shadow state and returns the response the
   // block must give for it. A frame tick picks bit c of the byte pair
   // {RAM[i + 64], RAM[i]} for each segment i, c being the current common.
   // A common count of zero scans one line, counts above the maxima
   // saturate, and a counter left above a lowered count is used as it is
   // before it wraps.
   function automatic lcd_response_type display_response(input lcd_request_type req);
      lcd_response_type rsp;
      int               segs;
      int               commons;
      logic [15:0]      pair;
      rsp = '0;
      case (req.kind)
         lcdseg_pkg::KIND_WRITE: begin
            shadow_ram[req.address] = req.write_data;
         end
         lcdseg_pkg::KIND_READ: begin
            rsp.read_data = shadow_ram[req.address];
         end
         lcdseg_pkg::KIND_TICK: begin
            segs = (int'(cfg_segments) > lcdseg_pkg::MAX_SEGMENTS) ?
                   lcdseg_pkg::MAX_SEGMENTS : int'(cfg_segments);
            if (cfg_commons == '0) begin
               commons = 1;
            end else if (int'(cfg_commons) > lcdseg_pkg::MAX_COMMONS) begin
               commons = lcdseg_pkg::MAX_COMMONS;
            end else begin
               commons = int'(cfg_commons);
            end
            rsp.segments_valid = 1'b1;
            rsp.common_index   = scan_common;
            for (int i = 0; i < segs; i++) begin
               pair = {shadow_ram[i + 64], shadow_ram[i]};
               rsp.segments[i] = pair[scan_common];
            end
            scan_common = lcdseg_pkg::COM_IW'((int'(scan_common) + 1) % commons);
         end
         default: begin
            // The unused kind changes nothing and answers with all zeros.
         end
      endcase
      return rsp;
   endfunction

   function automatic lcd_request_type make_request(
         input logic [lcdseg_pkg::KIND_W-1:0] kind,
         input logic [lcdseg_pkg::RAM_AW-1:0] address,
         input logic [lcdseg_pkg::DATA_W-1:0] write_data);
      lcd_request_type req;
      req.kind       = kind;
      req.address    = address;
      req.write_data = write_data;
      return req;
   endfunction

   function automatic lcd_request_type random_request();
      lcd_request_type req;
      int              pick;
      pick           = int'($urandom_range(0, 99));
      req.address    = lcdseg_pkg::RAM_AW'($urandom_range(0, lcdseg_pkg::RAM_DEPTH - 1));
      req.write_data = lcdseg_pkg::DATA_W'($urandom_range(0, 255));
      if (pick < 40) begin
         req.kind = lcdseg_pkg::KIND_WRITE;
         // Half of the writes land on bytes that a frame tick scans, in either
         // the low or the high plane.
         if (pick < 20) begin
            req.address = lcdseg_pkg::RAM_AW'($urandom_range(0, lcdseg_pkg::MAX_SEGMENTS - 1))
                          | ($urandom_range(0, 1) ? lcdseg_pkg::HIGH_PLANE : '0);
         end
      end else if (pick < 65) begin
         req.kind = lcdseg_pkg::KIND_READ;
      end else if (pick < 95) begin
         req.kind = lcdseg_pkg::KIND_TICK;
      end else begin
         req.kind = KIND_UNUSED;
      end
      return req;
   endfunction

   // Request driver. The request stays offered until the block takes it; the
   // expected response is computed at the edge that accepts the transaction.
   always @(posedge clock) begin
      logic offering;
      offering = push;
      if (reset) begin
         offering   = 1'b0;
         sender_gap = 0;
      end else begin
         if (push && !full) begin
            expected_responses.push_back(display_response(offered_request));
            offering = 1'b0;
            if ($urandom_range(0, 31) == 0) begin
               sender_calm = !sender_calm;
            end
            sender_gap = sender_calm ? 0 : int'($urandom_range(0, MAX_IDLE_CYCLES));
         end
         if (!offering) begin
            if (sender_gap > 0) begin
               sender_gap--;
            end else if (pending_requests.size() > 0) begin
               offered_request = pending_requests.pop_front();
               offering        = 1'b1;
            end
         end
      end
      push           <= offering;
      req_kind       <= offered_request.kind;
      req_address    <= offered_request.address;
      req_write_data <= offered_request.write_data;
   end

   // Response monitor. Besides the random idling it stops popping for a long
   // stretch every 300 responses, which backs the block up into its input.
   always @(posedge clock) begin
      logic             taking;
      lcd_response_type want;
      taking = pop;
      if (reset) begin
         taking = 1'b0;
      end else begin
         if (pop && !empty) begin
            if (expected_responses.size() == 0) begin
               $error("response transaction with no request outstanding");
               error_count++;
            end else begin
               want = expected_responses.pop_front();
               if (rsp_read_data !== want.read_data) begin
                  $error("read_data: expected %0h, actual %0h",
                         want.read_data, rsp_read_data);
                  error_count++;
               end
               if (rsp_segments_valid !== want.segments_valid) begin
                  $error("segments_valid: expected %0b, actual %0b",
                         want.segments_valid, rsp_segments_valid);
                  error_count++;
               end
               if (rsp_common_index !== want.common_index) begin
                  $error("common_index: expected %0d, actual %0d",
                         want.common_index, rsp_common_index);
                  error_count++;
               end
               if (rsp_segments !== want.segments) begin
                  $error("segments: expected %h, actual %h",
                         want.segments, rsp_segments);
                  error_count++;
               end
            end
            responses_taken++;
            if (responses_taken % 300 == 60) begin
               receiver_hold = HOLD_CYCLES;
            end
            if ($urandom_range(0, 31) == 0) begin
               receiver_calm = !receiver_calm;
            end
            receiver_gap = receiver_calm ? 0 : int'($urandom_range(0, MAX_IDLE_CYCLES));
         end
         if (receiver_hold > 0) begin
            receiver_hold--;
            taking = 1'b0;
         end else if (receiver_gap > 0) begin
            receiver_gap--;
            taking = 1'b0;
         end else begin
            taking = 1'b1;
         end
      end
      pop <= taking;
   end

   // Register writes update the shadow counts. They only happen while the
   // block is idle, so no request is being predicted at the same time.
   always @(posedge clock) begin
      if (!reset && csr_valid && csr_ready) begin
         case (csr_index)
            lcdseg_pkg::CSR_COMMON_COUNT: begin
               cfg_commons = csr_data[lcdseg_pkg::CFG_COM_W-1:0];
            end
            lcdseg_pkg::CSR_SEGMENT_COUNT: begin
               cfg_segments = csr_data[lcdseg_pkg::CFG_SEG_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   task automatic write_register(input logic [lcdseg_pkg::CSR_IDX_W-1:0]  index,
                                 input logic [lcdseg_pkg::CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // Waits until nothing is queued, offered or expected, then lets the
   // block sit quiet.
   task automatic wait_until_drained();
      do @(negedge clock);
      while (pending_requests.size() != 0 || push || expected_responses.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      logic [lcdseg_pkg::CSR_DATA_W-1:0] phase_commons  [RANDOM_PHASES];
      logic [lcdseg_pkg::CSR_DATA_W-1:0] phase_segments [RANDOM_PHASES];
      int                                ticks;

      foreach (shadow_ram[a]) begin
         shadow_ram[a] = '0;
      end
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed part under the reset counts: address and data extremes, both
      // RAM planes, a never-written byte, a full wrap of the eight commons and
      // the unused kind.
      pending_requests.push_back(make_request(lcdseg_pkg::KIND_WRITE, 7'd0,   8'hff));
      pending_requests.push_back(make_request(lcdseg_pkg::KIND_WRITE, 7'd127, 8'h80));
      pending_requests.push_back(make_request(lcdseg_pkg::KIND_WRITE, 7'd64,  8'ha5));
      pending_requests.push_back(make_request(lcdseg_pkg::KIND_WRITE, 7'd41,  8'h01));
      pending_requests.push_back(make_request(lcdseg_pkg::KIND_WRITE, 7'd105, 8'h80));
      pending_requests.push_back(make_request(lcdseg_pkg::KIND_WRITE, 7'd63,  8'hff));
      pending_requests.push_back(make_request(lcdseg_pkg::KIND_READ,  7'd0,   8'h00));
      pending_requests.push_back(make_request(lcdseg_pkg::KIND_READ,  7'd127, 8'hff));
      pending_requests.push_back(make_request(lcdseg_pkg::KIND_READ,  7'd64,  8'h00));
      pending_requests.push_back(make_request(lcdseg_pkg::KIND_READ,  7'd90,  8'h00));
      repeat (9) begin
         pending_requests.push_back(make_request(lcdseg_pkg::KIND_TICK, 7'd127, 8'hff));
      end
      pending_requests.push_back(make_request(KIND_UNUSED,            7'd0, 8'h00));
      pending_requests.push_back(make_request(lcdseg_pkg::KIND_READ,  7'd0, 8'h00));
      pending_requests.push_back(make_request(lcdseg_pkg::KIND_WRITE, 7'd0, 8'h5a));
      pending_requests.push_back(make_request(lcdseg_pkg::KIND_READ,  7'd0, 8'h00));
      wait_until_drained();

      // Leave the counter high under sixteen commons, then lower the count
      // below it: the next tick still uses the old counter before wrapping.
      write_register(lcdseg_pkg::CSR_COMMON_COUNT, 6'd16);
      write_register(lcdseg_pkg::CSR_SEGMENT_COUNT, 6'd42);
      ticks = (12 - int'(scan_common) + 16) % 16;
      repeat (ticks) begin
         pending_requests.push_back(make_request(lcdseg_pkg::KIND_TICK, '0, '0));
      end
      wait_until_drained();
      write_register(lcdseg_pkg::CSR_COMMON_COUNT, 6'd5);
      repeat (6) begin
         pending_requests.push_back(make_request(lcdseg_pkg::KIND_TICK, '0, '0));
      end
      wait_until_drained();

      // Random part: one batch per pair of counts, including zero counts,
      // exact maxima, saturating values, a common value with the bit above
      // the register set, and one random pair.
      phase_commons  = '{6'd8,  6'd1, 6'd0, 6'd16, 6'd31, 6'd17,
                         6'd3,  6'd5, 6'd2, 6'd40, 6'd13, 6'd0};
      phase_segments = '{6'd42, 6'd1, 6'd0, 6'd42, 6'd63, 6'd43,
                         6'd7,  6'd20, 6'd41, 6'd33, 6'd2, 6'd0};
      phase_commons[RANDOM_PHASES - 1]  = lcdseg_pkg::CSR_DATA_W'($urandom_range(0, 63));
      phase_segments[RANDOM_PHASES - 1] = lcdseg_pkg::CSR_DATA_W'($urandom_range(0, 63));
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         write_register(lcdseg_pkg::CSR_COMMON_COUNT, phase_commons[p]);
         write_register(lcdseg_pkg::CSR_SEGMENT_COUNT, phase_segments[p]);
         repeat (PHASE_REQUESTS) begin
            pending_requests.push_back(random_request());
         end
         wait_until_drained();
      end

      repeat (120) @(posedge clock);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // Watchdog: several times the slowest correct run.
   initial begin
      #(20 * 700000);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

`default_nettype wire

[filelist.f]
+incdir+sv
sv/lcdseg_pkg.sv
sv/lcdseg_ram.sv
sv/lcdseg_front.sv
sv/lcdseg_back.sv
sv/lcd_segment_ram_scan_driver.sv
tb/tb_top.sv
